@@ sv/ame_pkg.sv @@
// Shared types and constants for the accumulator machine execute unit.
`default_nettype none
package ame_pkg;

	localparam int MEM_WORDS = 128;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int WORD_W    = 32;
	localparam int PC_W      = 7;
	localparam int CMD_W     = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PC_W-1:0]   pc_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 4'd0,
		CMD_WRITE  = 4'd1,
		CMD_LOAD   = 4'd2,
		CMD_STORE  = 4'd3,
		CMD_ADD    = 4'd4,
		CMD_SUB    = 4'd5,
		CMD_MUL    = 4'd6,
		CMD_DIV    = 4'd7,
		CMD_BR     = 4'd8,
		CMD_BRNEG  = 4'd9,
		CMD_BRZERO = 4'd10,
		CMD_BRPOS  = 4'd11,
		CMD_HALT   = 4'd12,
		CMD_SKIP   = 4'd13
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Status returned by the divider to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

@@ sv/ame_if.sv @@
// Valid/ready channel interfaces for operation beats and result beats.
`default_nettype none
interface ame_op_if;
	logic                            valid;
	logic                            ready;
	logic [ame_pkg::CMD_W-1:0]       cmd;
	logic [ame_pkg::PC_W-1:0]        operand_addr;
	logic signed [ame_pkg::WORD_W-1:0] in_word;

	modport source (output valid, cmd, operand_addr, in_word, input ready);
	modport sink (input valid, cmd, operand_addr, in_word, output ready);
endinterface

interface ame_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [ame_pkg::WORD_W-1:0] acc_value;
	logic [ame_pkg::PC_W-1:0]          next_pc;
	logic signed [ame_pkg::WORD_W-1:0] out_word;
	logic                              out_valid;
	logic                              halted;
	logic                              div_error;

	modport source (output valid, acc_value, next_pc, out_word, out_valid, halted, div_error,
		input ready);
	modport sink (input valid, acc_value, next_pc, out_word, out_valid, halted, div_error,
		output ready);
endinterface
`default_nettype wire

@@ sv/ame_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module ame_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ sv/ame_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ame_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ame_pkg::word_t num,
	input  wire ame_pkg::word_t den,
	output ame_pkg::div_stat_t stat,
	output ame_pkg::word_t     quo
);
	import ame_pkg::*;

	localparam int CNT_W = $clog2(WORD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	word_t            rem_q;
	word_t            quo_q;
	word_t            den_q;
	logic [WORD_W:0]  rem_sh;
	logic [WORD_W:0]  rem_sub;

	assign rem_sh  = {rem_q, quo_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
			rem_q <= '0;
			quo_q <= num[WORD_W-1] ? (word_t'(0) - num) : num;
			den_q <= den[WORD_W-1] ? (word_t'(0) - den) : den;
		end else if (busy_q) begin
			if (!rem_sub[WORD_W]) begin
				rem_q <= rem_sub[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = neg_q ? (word_t'(0) - quo_q) : quo_q;
endmodule
`default_nettype wire

@@ sv/accumulator_machine_execute.sv @@
// Top level: sequencer, word memory, accumulator and result register.
// An operation goes from accept to result through read, execute and finish;
// multiply also passes ST_MUL and a divide waits in ST_DIV on the bit-serial divider.
// One operation is in flight at a time; the next is accepted only after the finish.
// Asynchronous reset clears accumulator, pc, halt flag and the memory valid
// bits; a word never written since reset reads as zero, with no clearing pass.
`default_nettype none
module accumulator_machine_execute (
	input  wire logic clk,
	input  wire logic arst_n,
	ame_op_if.sink    op,
	ame_res_if.source res
);
	import ame_pkg::*;

	state_t           state_q;
	state_t           state_nxt;

	logic [CMD_W-1:0] cmd_q;
	pc_t              addr_q;
	word_t            word_q;
	word_t            acc_q;
	pc_t              pc_q;
	logic             halt_q;
	word_t            rword_q;
	logic             routv_q;
	logic             rderr_q;
	word_t            prod_s1;
	logic [MEM_WORDS-1:0] vld_q;

	logic             ovld_q;
	word_t            oacc_q;
	pc_t              opc_q;
	word_t            oword_q;
	logic             ooutv_q;
	logic             ohalt_q;
	logic             oderr_q;

	logic             accept;
	logic             slot_free;
	logic             ram_we;
	logic [MEM_AW-1:0] ram_addr;
	word_t            ram_wdata;
	word_t            ram_rdata;
	logic             in_range;
	logic [MEM_AW-1:0] idx_q;
	word_t            mem_data;
	pc_t              pc_adv;
	logic             div_start;
	div_stat_t        div_stat;
	word_t            div_quo;

	assign accept    = op.valid && op.ready;
	assign slot_free = !ovld_q || res.ready;
	assign idx_q     = MEM_AW'(addr_q);
	assign in_range  = 32'(addr_q) < 32'(MEM_WORDS);
	assign mem_data  = (in_range && vld_q[idx_q]) ? ram_rdata : '0;
	assign pc_adv    = pc_q + 1'b1;

	ame_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	ame_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc_q),
		.den   (mem_data),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (op.valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (halt_q) begin
					state_nxt = ST_DONE;
				end else if (cmd_q == CMD_MUL) begin
					state_nxt = ST_MUL;
				end else if (cmd_q == CMD_DIV && mem_data != '0) begin
					state_nxt = ST_DIV;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_MUL: state_nxt = ST_DONE;
			ST_DIV: begin
				if (div_stat.done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		op.ready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = MEM_AW'(op.operand_addr);
		ram_wdata = (cmd_q == CMD_READ) ? word_q : acc_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: op.ready = 1'b1;
			ST_EXEC: begin
				ram_addr  = idx_q;
				ram_we    = !halt_q && in_range
					&& (cmd_q == CMD_READ || cmd_q == CMD_STORE);
				div_start = !halt_q && cmd_q == CMD_DIV && mem_data != '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			vld_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ram_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (state_q == ST_EXEC && !halt_q) begin
				case (cmd_q)
					CMD_READ, CMD_WRITE, CMD_STORE, CMD_MUL, CMD_DIV, CMD_SKIP: pc_q <= pc_adv;
					CMD_LOAD: begin
						acc_q <= mem_data;
						pc_q  <= pc_adv;
					end
					CMD_ADD: begin
						acc_q <= acc_q + mem_data;
						pc_q  <= pc_adv;
					end
					CMD_SUB: begin
						acc_q <= acc_q - mem_data;
						pc_q  <= pc_adv;
					end
					CMD_BR:     pc_q <= addr_q;
					CMD_BRNEG:  pc_q <= acc_q[WORD_W-1] ? addr_q : pc_adv;
					CMD_BRZERO: pc_q <= (acc_q == '0) ? addr_q : pc_adv;
					CMD_BRPOS:  pc_q <= (acc_q != '0 && !acc_q[WORD_W-1]) ? addr_q : pc_adv;
					CMD_HALT:   halt_q <= 1'b1;
					default: begin
					end
				endcase
			end
			if (state_q == ST_MUL) begin
				acc_q <= prod_s1;
			end
			if (state_q == ST_DIV && div_stat.done) begin
				acc_q <= div_quo;
			end
			if (state_q == ST_DONE && slot_free) begin
				ovld_q <= 1'b1;
			end else if (res.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// Operation capture, per-item result flags and the result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= op.cmd;
			addr_q <= op.operand_addr;
			word_q <= op.in_word;
		end
		if (state_q == ST_EXEC) begin
			prod_s1 <= acc_q * mem_data;
			rword_q <= (!halt_q && cmd_q == CMD_WRITE) ? mem_data : '0;
			routv_q <= !halt_q && cmd_q == CMD_WRITE;
			rderr_q <= !halt_q && cmd_q == CMD_DIV && mem_data == '0;
		end
		if (state_q == ST_DONE && slot_free) begin
			oacc_q  <= acc_q;
			opc_q   <= pc_q;
			oword_q <= rword_q;
			ooutv_q <= routv_q;
			ohalt_q <= halt_q;
			oderr_q <= rderr_q;
		end
	end

	assign res.valid     = ovld_q;
	assign res.acc_value = oacc_q;
	assign res.next_pc   = opc_q;
	assign res.out_word  = oword_q;
	assign res.out_valid = ooutv_q;
	assign res.halted    = ohalt_q;
	assign res.div_error = oderr_q;

	// Busy flag of the divider is informational; the sequencer waits on done.
	logic div_busy_unused;
	assign div_busy_unused = div_stat.busy;
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the accumulator machine execute unit: directed table, random programs, predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ame_pkg::*;

	// Command codes that the package leaves unnamed. The unit must treat them as no-ops.
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 4'd14;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 4'd15;

	localparam word_t WORD_MAX = 32'h7FFF_FFFF;
	localparam word_t WORD_MIN = 32'h8000_0000;
	localparam word_t WORD_M1  = 32'hFFFF_FFFF;
	localparam word_t WORD_PAT = 32'hA5A5_5A5A;

	localparam int RANDOM_OPS  = 1400;
	localparam int DRAIN_WAIT  = 60;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		pc_t              addr;
		word_t            word;
	} op_beat_t;

	typedef struct packed {
		word_t acc_value;
		pc_t   next_pc;
		word_t out_word;
		logic  out_valid;
		logic  halted;
		logic  div_error;
	} exec_res_t;

	typedef struct packed {
		op_beat_t  op;
		logic      at_end;
		logic      typed;
		exec_res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ame_op_if  op_ch ();
	ame_res_if res_ch ();

	accumulator_machine_execute i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_ch),
		.res    (res_ch)
	);

	// Shadow copy of the machine state.
	word_t shadow_mem [MEM_WORDS];
	word_t shadow_acc;
	pc_t   shadow_pc;
	logic  shadow_halt;

	exec_res_t pending_results [$];
	dir_row_t  dir_tab [$];
	int        mismatch_cnt;
	bit        no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return WORD_MAX;
			2: return WORD_MIN;
			3: return WORD_M1;
			4: return 32'd1;
			5, 6: return word_t'($signed($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic pc_t rand_addr();
		if ($urandom_range(0, 9) < 7)
			return pc_t'($urandom_range(0, 15));
		return pc_t'($urandom_range(0, MEM_WORDS - 1));
	endfunction

	function automatic op_beat_t mk_op(input logic [CMD_W-1:0] cmd, input pc_t addr,
		input word_t word);
		op_beat_t b;
		b.cmd  = cmd;
		b.addr = addr;
		b.word = word;
		return b;
	endfunction

	function automatic exec_res_t mk_res(input word_t acc, input pc_t pc, input word_t ow,
		input logic ov, input logic hlt, input logic derr);
		exec_res_t r;
		r.acc_value = acc;
		r.next_pc   = pc;
		r.out_word  = ow;
		r.out_valid = ov;
		r.halted    = hlt;
		r.div_error = derr;
		return r;
	endfunction

	// Signed divide truncating toward zero, on two's complement magnitudes.
	function automatic word_t sdiv_trunc(input word_t num, input word_t den);
		word_t un;
		word_t ud;
		word_t q;
		un = num[WORD_W-1] ? -num : num;
		ud = den[WORD_W-1] ? -den : den;
		q  = un / ud;
		return (num[WORD_W-1] != den[WORD_W-1]) ? -q : q;
	endfunction

	// Executes one operation on the shadow state and returns the result beat it should cause.
	function automatic exec_res_t execute_op(input op_beat_t b);
		exec_res_t r;
		word_t     m;
		pc_t       adv;
		r   = '0;
		m   = shadow_mem[b.addr];
		adv = shadow_pc + 1'b1;
		if (!shadow_halt) begin
			case (b.cmd)
				CMD_READ: begin
					shadow_mem[b.addr] = b.word;
					shadow_pc = adv;
				end
				CMD_WRITE: begin
					r.out_word  = m;
					r.out_valid = 1'b1;
					shadow_pc   = adv;
				end
				CMD_LOAD: begin
					shadow_acc = m;
					shadow_pc  = adv;
				end
				CMD_STORE: begin
					shadow_mem[b.addr] = shadow_acc;
					shadow_pc = adv;
				end
				CMD_ADD: begin
					shadow_acc = shadow_acc + m;
					shadow_pc  = adv;
				end
				CMD_SUB: begin
					shadow_acc = shadow_acc - m;
					shadow_pc  = adv;
				end
				CMD_MUL: begin
					shadow_acc = shadow_acc * m;
					shadow_pc  = adv;
				end
				CMD_DIV: begin
					if (m == '0)
						r.div_error = 1'b1;
					else
						shadow_acc = sdiv_trunc(shadow_acc, m);
					shadow_pc = adv;
				end
				CMD_BR: shadow_pc = b.addr;
				CMD_BRNEG: shadow_pc = shadow_acc[WORD_W-1] ? b.addr : adv;
				CMD_BRZERO: shadow_pc = (shadow_acc == '0) ? b.addr : adv;
				CMD_BRPOS: begin
					shadow_pc = (shadow_acc != '0 && !shadow_acc[WORD_W-1]) ? b.addr : adv;
				end
				CMD_HALT: shadow_halt = 1'b1;
				CMD_SKIP: shadow_pc = adv;
				default: ;
			endcase
		end
		r.acc_value = shadow_acc;
		r.next_pc   = shadow_pc;
		r.halted    = shadow_halt;
		return r;
	endfunction

	task automatic put_row(input logic [CMD_W-1:0] cmd, input pc_t addr, input word_t word,
		input logic at_end, input logic typed, input exec_res_t want);
		dir_row_t row;
		row.op     = mk_op(cmd, addr, word);
		row.at_end = at_end;
		row.typed  = typed;
		row.want   = want;
		dir_tab.push_back(row);
	endtask

	// Presents one operation beat and records its expected result once it is accepted.
	task automatic issue_op(input op_beat_t b, input logic typed, input exec_res_t want);
		int        gap;
		exec_res_t pred;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			op_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_ch.valid        <= 1'b1;
		op_ch.cmd          <= b.cmd;
		op_ch.operand_addr <= b.addr;
		op_ch.in_word      <= b.word;
		do
			@(posedge clk);
		while (!op_ch.ready);
		pred = execute_op(b);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic send_rand(input logic [CMD_W-1:0] cmd, input pc_t addr);
		issue_op(mk_op(cmd, addr, rand_word()), 1'b0, '0);
	endtask

	// Result side: random stalls, and a check of each beat against the oldest expectation.
	initial begin
		int hold;
		hold = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (no_idle || $urandom_range(0, 3) != 0) begin
				res_ch.ready <= 1'b1;
				hold = $urandom_range(0, 8);
			end else begin
				res_ch.ready <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		exec_res_t got;
		exec_res_t want;
		if (res_ch.valid && res_ch.ready) begin
			got = {res_ch.acc_value, res_ch.next_pc, res_ch.out_word, res_ch.out_valid,
				res_ch.halted, res_ch.div_error};
			if (pending_results.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected result beat: acc %h pc %0d", got.acc_value, got.next_pc);
				mismatch_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (got.acc_value !== want.acc_value || got.next_pc !== want.next_pc ||
					got.out_word !== want.out_word || got.out_valid !== want.out_valid ||
					got.halted !== want.halted || got.div_error !== want.div_error) begin
					if (mismatch_cnt < 10) begin
						$display("mismatch exp: acc %h pc %0d out %h ov %b hlt %b derr %b",
							want.acc_value, want.next_pc, want.out_word, want.out_valid,
							want.halted, want.div_error);
						$display("         got: acc %h pc %0d out %h ov %b hlt %b derr %b",
							got.acc_value, got.next_pc, got.out_word, got.out_valid,
							got.halted, got.div_error);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		int   n;
		int   k;
		pc_t  a;
		pc_t  c;
		logic [CMD_W-1:0] arith;

		op_ch.valid        <= 1'b0;
		op_ch.cmd          <= CMD_SKIP;
		op_ch.operand_addr <= '0;
		op_ch.in_word      <= '0;
		mismatch_cnt = 0;
		no_idle      = 1'b0;
		for (int i = 0; i < MEM_WORDS; i++)
			shadow_mem[i] = '0;
		shadow_acc  = '0;
		shadow_pc   = '0;
		shadow_halt = 1'b0;

		// Rows typed in by hand start from the cleared reset state.
		put_row(CMD_LOAD, 7'd5, WORD_M1, 1'b0, 1'b1, mk_res('0, 7'd1, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_WRITE, 7'd127, '0, 1'b0, 1'b1, mk_res('0, 7'd2, '0, 1'b1, 1'b0, 1'b0));
		put_row(CMD_DIV, 7'd9, '0, 1'b0, 1'b1, mk_res('0, 7'd3, '0, 1'b0, 1'b0, 1'b1));
		put_row(CMD_READ, 7'd0, WORD_MAX, 1'b0, 1'b1, mk_res('0, 7'd4, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_READ, 7'd1, WORD_MIN, 1'b0, 1'b1, mk_res('0, 7'd5, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_READ, 7'd2, WORD_M1, 1'b0, 1'b1, mk_res('0, 7'd6, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_READ, 7'd127, WORD_PAT, 1'b0, 1'b1,
			mk_res('0, 7'd7, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_LOAD, 7'd1, '0, 1'b0, 1'b1, mk_res(WORD_MIN, 7'd8, '0, 1'b0, 1'b0, 1'b0));
		// The most negative word divided by minus one wraps back to itself.
		put_row(CMD_DIV, 7'd2, '0, 1'b0, 1'b1, mk_res(WORD_MIN, 7'd9, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_BRNEG, 7'd100, '0, 1'b0, 1'b1,
			mk_res(WORD_MIN, 7'd100, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_ADD, 7'd0, '0, 1'b0, 1'b0, '0);
		put_row(CMD_SUB, 7'd2, '0, 1'b0, 1'b0, '0);
		put_row(CMD_BRZERO, 7'd126, '0, 1'b0, 1'b0, '0);
		put_row(CMD_STORE, 7'd3, '0, 1'b0, 1'b0, '0);
		// The program counter wraps from 127 to 0.
		put_row(CMD_SKIP, 7'd0, '0, 1'b0, 1'b1, mk_res('0, 7'd0, '0, 1'b0, 1'b0, 1'b0));
		put_row(CMD_LOAD, 7'd0, '0, 1'b0, 1'b0, '0);
		put_row(CMD_MUL, 7'd0, '0, 1'b0, 1'b0, '0);
		put_row(CMD_BRPOS, 7'd64, '0, 1'b0, 1'b0, '0);
		put_row(CMD_BR, 7'd10, '0, 1'b0, 1'b0, '0);
		put_row(CMD_WRITE, 7'd0, '0, 1'b0, 1'b0, '0);
		put_row(CMD_DIV, 7'd127, '0, 1'b0, 1'b0, '0);
		put_row(CMD_RSVD_A, 7'd127, WORD_M1, 1'b0, 1'b0, '0);
		put_row(CMD_RSVD_B, 7'd85, WORD_PAT, 1'b0, 1'b0, '0);
		put_row(CMD_WRITE, 7'd127, '0, 1'b0, 1'b0, '0);
		// A halt cannot be undone without reset, so these rows close the run.
		put_row(CMD_HALT, 7'd0, '0, 1'b1, 1'b0, '0);
		put_row(CMD_ADD, 7'd0, '0, 1'b1, 1'b0, '0);
		put_row(CMD_WRITE, 7'd127, '0, 1'b1, 1'b0, '0);
		put_row(CMD_BRZERO, 7'd3, '0, 1'b1, 1'b0, '0);
		put_row(CMD_HALT, 7'd9, '0, 1'b1, 1'b0, '0);
		put_row(CMD_RSVD_B, 7'd0, '0, 1'b1, 1'b0, '0);

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (dir_tab[i])
			if (!dir_tab[i].at_end)
				issue_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);

		n = 0;
		k = 0;
		while (n < RANDOM_OPS) begin
			if (n / 150 != k) begin
				k = n / 150;
				no_idle = ($urandom_range(0, 3) == 0);
				if (k % 2 == 0) begin
					// Let the unit drain completely before going on.
					op_ch.valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				// Short program: read a word, load it, combine it with memory, store, branch, print.
				a = rand_addr();
				c = rand_addr();
				case ($urandom_range(0, 3))
					0: arith = CMD_ADD;
					1: arith = CMD_SUB;
					2: arith = CMD_MUL;
					default: arith = CMD_DIV;
				endcase
				send_rand(CMD_READ, a);
				send_rand(CMD_LOAD, a);
				send_rand(arith, rand_addr());
				send_rand(CMD_STORE, c);
				case ($urandom_range(0, 3))
					0: send_rand(CMD_BRNEG, pc_t'($urandom));
					1: send_rand(CMD_BRZERO, pc_t'($urandom));
					2: send_rand(CMD_BRPOS, pc_t'($urandom));
					default: send_rand(CMD_BR, pc_t'($urandom));
				endcase
				send_rand(CMD_WRITE, c);
				n += 6;
			end else begin
				arith = 4'($urandom_range(0, 15));
				if (arith == CMD_HALT)
					arith = CMD_SKIP;
				send_rand(arith, ($urandom_range(0, 1) == 0) ? rand_addr() : pc_t'($urandom));
				n++;
			end
		end

		no_idle = 1'b0;
		foreach (dir_tab[i])
			if (dir_tab[i].at_end)
				issue_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
		op_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
